// ----- rtl/aews_pkg.sv -----
// Package for the automation event window scheduler.
// Holds item kinds, register indexes, tempo limits and arithmetic widths.
// No dependencies.
package aews_pkg;

  typedef enum logic [1:0] {
    KIND_APPEND   = 2'd0,
    KIND_SEEK     = 2'd1,
    KIND_GENERATE = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_e;

  typedef enum logic {
    REG_SAMPLE_RATE = 1'b0,
    REG_TEMPO       = 1'b1
  } reg_idx_e;

  localparam int unsigned DEF_EVENT_DEPTH   = 1024;
  localparam int unsigned DEF_TICKS_PER_BAR = 32;

  localparam logic [17:0] RATE_RESET  = 18'd48000;
  localparam logic [15:0] TEMPO_RESET = 16'd30720;
  localparam logic [15:0] BPM_MIN_Q8  = 16'd10240;
  localparam logic [15:0] BPM_MAX_Q8  = 16'd64000;
  localparam logic [6:0]  MAX_OUT     = 7'd64;

  // Scaled sample positions: tick * rate * 15 << 15 plus phase terms.
  localparam int unsigned POS_W = 64;
  localparam int unsigned ENT_W = 46;

endpackage

// ----- rtl/automation_event_window_scheduler.sv -----
// Automation event window scheduler, top level.
// Event table memory, tick-to-sample conversion on one shared multiplier,
// and a bit-serial offset divider under one sequencer. Depends on aews_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------
//   in      | input     | in_valid_i / in_stall_o   | kind, event fields, window fields
//   out     | output    | out_valid_o / out_stall_i | has_event, offset, event, last
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Append and clear are handled in the idle state. Seek does one memory read
// (S_SREAD) and one tick compare (S_SCMP) per table entry walked. Generate
// sets up the window on the shared multiplier (S_MUL0..S_MUL2, S_SEND),
// then reads, scales and compares each entry (S_READ, S_MULP, S_POS, S_CMP);
// emitted ones add the saturation check S_SAT, the divider S_DIV (skipped
// if it saturates) and S_HOLD. A final read check and S_FLUSH send the last item.
// Output stalls hold the sequencer in S_HOLD and S_FLUSH; input is stalled
// whenever the sequencer is not idle. Reset clears count, pointer and
// registers; the table is not cleared (only entries below the count are read).
module automation_event_window_scheduler #(
  parameter int unsigned EVENT_DEPTH   = aews_pkg::DEF_EVENT_DEPTH,
  parameter int unsigned TICKS_PER_BAR = aews_pkg::DEF_TICKS_PER_BAR
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [21:0] event_tick_i,
  input  logic [7:0]  event_track_i,
  input  logic [7:0]  event_controller_i,
  input  logic [7:0]  event_value_i,
  input  logic [15:0] bar_i,
  input  logic [7:0]  step_i,
  input  logic [23:0] step_phase_i,
  input  logic [15:0] num_frames_i,
  input  logic [6:0]  max_events_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        has_event_o,
  output logic [15:0] sample_offset_o,
  output logic [7:0]  out_track_o,
  output logic [7:0]  out_controller_o,
  output logic [7:0]  out_value_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [17:0] cfg_data_i
);
  import aews_pkg::*;

  localparam int unsigned AddrW = $clog2(EVENT_DEPTH);
  localparam int unsigned CntW  = $clog2(EVENT_DEPTH + 1);
  localparam int unsigned StW   = 17 + $clog2(TICKS_PER_BAR + 1);
  localparam int unsigned MulAW = (StW > 24) ? StW : 24;
  localparam int unsigned ProdW = MulAW + 18;

  typedef enum logic [3:0] {
    S_IDLE, S_SREAD, S_SCMP, S_MUL0, S_MUL1, S_MUL2, S_SEND,
    S_READ, S_MULP, S_POS, S_CMP, S_SAT, S_DIV, S_HOLD, S_FLUSH
  } state_e;

  typedef struct packed {
    logic [15:0] off;
    logic [7:0]  trk;
    logic [7:0]  ctl;
    logic [7:0]  val;
  } result_t;

  state_e state_q;

  logic [17:0] rate_q;
  logic [15:0] tempo_q;
  logic [15:0] bpm;

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] next_q;

  logic [ENT_W-1:0] mem_q [EVENT_DEPTH];
  logic [ENT_W-1:0] rd_q;
  logic [21:0]      rd_tick;

  logic [StW-1:0]   st_q;
  logic [23:0]      phase_q;
  logic [15:0]      frames_q;
  logic [6:0]       maxe_q;
  logic [6:0]       emitted_q;

  logic [MulAW-1:0] mul_a;
  logic [17:0]      mul_b;
  logic [ProdW-1:0] prod_q;

  logic [POS_W-1:0] acc_q;
  logic [POS_W-1:0] s_start_q;
  logic [POS_W-1:0] s_end_q;
  logic [POS_W-1:0] rem_q;
  logic [POS_W-1:0] den;
  logic [POS_W-1:0] den_sh;
  logic [POS_W-1:0] prod_x15;
  logic [15:0]      quo_q;
  logic [3:0]       bit_q;

  result_t pend_q;
  logic    have_pend_q;
  logic    out_free;
  logic    out_load;

  logic [15:0]    bar_m1;
  logic [StW-1:0] start_tick;

  // Clamp tempo to 40..250 BPM.
  always_comb begin
    bpm = tempo_q;
    if (tempo_q < BPM_MIN_Q8) bpm = BPM_MIN_Q8;
    if (tempo_q > BPM_MAX_Q8) bpm = BPM_MAX_Q8;
  end

  assign den      = POS_W'({bpm, 8'd0});
  assign den_sh   = den << bit_q;
  assign rd_tick  = rd_q[ENT_W-1 -: 22];
  assign prod_x15 = ((POS_W'(prod_q) << 4) - POS_W'(prod_q)) << 15;
  assign out_free = !out_valid_o || !out_stall_i;
  // A new item is loaded into the output register this cycle.
  assign out_load = ((state_q == S_HOLD) && have_pend_q && out_free) ||
                    ((state_q == S_FLUSH) && out_free);

  // Start tick of the window: (max(bar,1)-1)*TICKS_PER_BAR + 2*step.
  assign bar_m1     = (bar_i == 16'd0) ? 16'd0 : bar_i - 16'd1;
  assign start_tick = StW'(bar_m1) * StW'(TICKS_PER_BAR) + StW'({step_i, 1'b0});

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Shared multiplier operand select.
  always_comb begin
    mul_a = MulAW'(rd_tick);
    mul_b = rate_q;
    case (state_q)
      S_MUL0: begin
        mul_a = MulAW'(st_q);
        mul_b = rate_q;
      end
      S_MUL1: begin
        mul_a = MulAW'(phase_q);
        mul_b = 18'(bpm);
      end
      S_MUL2: begin
        mul_a = MulAW'(frames_q);
        mul_b = 18'(bpm);
      end
      default: begin
        mul_a = MulAW'(rd_tick);
        mul_b = rate_q;
      end
    endcase
  end

  // Event table: written on append, read at the pointer every cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && kind_i == KIND_APPEND &&
        count_q < CntW'(EVENT_DEPTH)) begin
      mem_q[count_q[AddrW-1:0]] <= {event_tick_i, event_track_i,
                                    event_controller_i, event_value_i};
    end
    rd_q <= mem_q[next_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      rate_q           <= RATE_RESET;
      tempo_q          <= TEMPO_RESET;
      count_q          <= '0;
      next_q           <= '0;
      have_pend_q      <= 1'b0;
      emitted_q        <= '0;
      out_valid_o      <= 1'b0;
      has_event_o      <= 1'b0;
      sample_offset_o  <= '0;
      out_track_o      <= '0;
      out_controller_o <= '0;
      out_value_o      <= '0;
      last_o           <= 1'b0;
    end else begin
      prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
      if (out_valid_o && !out_stall_i && !out_load) out_valid_o <= 1'b0;

      if (cfg_valid_i) begin
        if (cfg_index_i == REG_SAMPLE_RATE) rate_q <= cfg_data_i;
        else tempo_q <= cfg_data_i[15:0];
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            st_q     <= start_tick;
            phase_q  <= step_phase_i;
            frames_q <= num_frames_i;
            maxe_q   <= (max_events_i > MAX_OUT) ? MAX_OUT : max_events_i;
            case (kind_i)
              KIND_APPEND: begin
                if (count_q < CntW'(EVENT_DEPTH)) count_q <= count_q + CntW'(1);
              end
              KIND_SEEK: begin
                next_q  <= '0;
                state_q <= S_SREAD;
              end
              KIND_GENERATE: begin
                emitted_q   <= '0;
                have_pend_q <= 1'b0;
                state_q     <= S_MUL0;
              end
              default: begin
                count_q <= '0;
                next_q  <= '0;
              end
            endcase
          end
        end
        // Seek: walk entries until one is at or after the start tick or the count is reached.
        S_SREAD: begin
          state_q <= (next_q < count_q) ? S_SCMP : S_IDLE;
        end
        S_SCMP: begin
          if (StW'(rd_tick) < st_q) begin
            next_q  <= next_q + CntW'(1);
            state_q <= S_SREAD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        // Window bounds on the shared multiplier.
        S_MUL0: state_q <= S_MUL1;
        S_MUL1: begin
          acc_q   <= prod_x15;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          s_start_q <= acc_q + POS_W'(prod_q);
          state_q   <= S_SEND;
        end
        S_SEND: begin
          s_end_q <= s_start_q + (POS_W'(prod_q) << 8);
          state_q <= (maxe_q == '0 || rate_q == '0) ? S_FLUSH : S_READ;
        end
        // Per-entry loop.
        S_READ: begin
          state_q <= (next_q < count_q && emitted_q < maxe_q) ? S_MULP : S_FLUSH;
        end
        S_MULP: state_q <= S_POS;
        S_POS: begin
          acc_q   <= prod_x15;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (acc_q < s_start_q) begin
            next_q  <= next_q + CntW'(1);
            state_q <= S_READ;
          end else if (acc_q >= s_end_q) begin
            state_q <= S_FLUSH;
          end else begin
            rem_q   <= acc_q - s_start_q + POS_W'({bpm, 7'd0});
            state_q <= S_SAT;
          end
        end
        S_SAT: begin
          bit_q <= 4'd15;
          if (rem_q >= (den << 16)) begin
            quo_q   <= 16'hFFFF;
            state_q <= S_HOLD;
          end else begin
            quo_q   <= '0;
            state_q <= S_DIV;
          end
        end
        // Restoring division, one quotient bit a cycle.
        S_DIV: begin
          if (rem_q >= den_sh) begin
            rem_q        <= rem_q - den_sh;
            quo_q[bit_q] <= 1'b1;
          end
          if (bit_q == 4'd0) state_q <= S_HOLD;
          else bit_q <= bit_q - 4'd1;
        end
        // Send the previous event (not last), keep this one pending.
        S_HOLD: begin
          if (!have_pend_q || out_free) begin
            if (have_pend_q) begin
              out_valid_o      <= 1'b1;
              has_event_o      <= 1'b1;
              sample_offset_o  <= pend_q.off;
              out_track_o      <= pend_q.trk;
              out_controller_o <= pend_q.ctl;
              out_value_o      <= pend_q.val;
              last_o           <= 1'b0;
            end
            pend_q      <= '{off: quo_q, trk: rd_q[23:16], ctl: rd_q[15:8],
                             val: rd_q[7:0]};
            have_pend_q <= 1'b1;
            emitted_q   <= emitted_q + 7'd1;
            next_q      <= next_q + CntW'(1);
            state_q     <= S_READ;
          end
        end
        // Send the final item: the pending event, or an empty marker.
        S_FLUSH: begin
          if (out_free) begin
            out_valid_o      <= 1'b1;
            has_event_o      <= have_pend_q;
            sample_offset_o  <= have_pend_q ? pend_q.off : 16'd0;
            out_track_o      <= have_pend_q ? pend_q.trk : 8'd0;
            out_controller_o <= have_pend_q ? pend_q.ctl : 8'd0;
            out_value_o      <= have_pend_q ? pend_q.val : 8'd0;
            last_o           <= 1'b1;
            have_pend_q      <= 1'b0;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_event_o) |-> last_o)
    else $error("empty window item without last");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_q <= count_q) && (count_q <= CntW'(EVENT_DEPTH)))
    else $error("read pointer or count out of range");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD) |-> (emitted_q < maxe_q))
    else $error("more events than max_events");

endmodule
